@@ rtl/pkdet_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-window peak detector package
// Shared widths, register indexes, lane state and result types.
// ----------------------------------------------------------------------------
package pkdet_pkg;

    localparam int INDEX_BITS = 32;
    localparam int TSTAT_BITS = 24;
    localparam int LEVEL_BITS = TSTAT_BITS + 1;
    localparam int MASK_BITS  = INDEX_BITS + 1;
    localparam int WIN_BITS   = 12;
    localparam int POS_BITS   = 32;
    localparam int CFG_BITS   = 24;
    localparam int CFG_IDX_BITS = 3;

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = 2;
    localparam int OUTQ_CW    = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_RISE_MIN        = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SHORT_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG_THRESHOLD  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SHORT_WINDOW    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG_WINDOW     = 3'd4;

    localparam logic [LEVEL_BITS-1:0] TS_INF = {1'b1, {TSTAT_BITS{1'b0}}};
    localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};

    typedef struct packed {
        logic [LEVEL_BITS-1:0] level;
        logic [INDEX_BITS-1:0] sample;
        logic                  is_open;
        logic                  confirmed;
    } lane_state_t;

    localparam lane_state_t LANE_RESET = '{
        level:     TS_INF,
        sample:    '0,
        is_open:   1'b0,
        confirmed: 1'b0
    };

    typedef struct packed {
        lane_state_t           next;
        logic                  emit;
        logic                  was_open;
        logic [LEVEL_BITS-1:0] upd_level;
        logic [INDEX_BITS-1:0] upd_sample;
    } lane_out_t;

    typedef struct packed {
        logic [POS_BITS-1:0] peak_position;
        logic                from_long_window;
        logic                last_of_item;
    } result_t;

endpackage

@@ rtl/pkdet_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak detector lane
// One channel's trough tracking, peak following, confirmation and hold-off.
// ----------------------------------------------------------------------------
module pkdet_lane (
    input  logic [pkdet_pkg::TSTAT_BITS-1:0] cur,
    input  logic [pkdet_pkg::INDEX_BITS-1:0] idx,
    input  pkdet_pkg::lane_state_t           state,
    input  logic [pkdet_pkg::TSTAT_BITS-1:0] rise_min,
    input  logic [pkdet_pkg::TSTAT_BITS-1:0] threshold,
    input  logic [pkdet_pkg::WIN_BITS-1:0]   window,
    output pkdet_pkg::lane_out_t             result
);

    logic [pkdet_pkg::LEVEL_BITS-1:0] cur_x;
    logic [pkdet_pkg::LEVEL_BITS-1:0] ph_x;
    logic [pkdet_pkg::LEVEL_BITS-1:0] thr_x;
    logic [pkdet_pkg::LEVEL_BITS-1:0] lv1;
    logic [pkdet_pkg::INDEX_BITS-1:0] sp1;
    logic [pkdet_pkg::INDEX_BITS-1:0] half_win;
    logic                             conf1;

    assign cur_x    = {1'b0, cur};
    assign ph_x     = {1'b0, rise_min};
    assign thr_x    = {1'b0, threshold};
    assign half_win = pkdet_pkg::INDEX_BITS'(window >> 1);

    // The peak follows the running maximum while it is open.
    assign lv1 = (cur_x > state.level) ? cur_x : state.level;
    assign sp1 = (cur_x > state.level) ? idx : state.sample;

    assign conf1 = state.confirmed
                 | ((lv1 > cur_x) && ((lv1 - cur_x) > ph_x) && (lv1 > thr_x));

    always_comb
    begin
        result            = '0;
        result.next       = state;
        result.emit       = 1'b0;
        result.was_open   = state.is_open;
        result.upd_level  = lv1;
        result.upd_sample = sp1;
        if (!state.is_open)
        begin
            if (cur_x < state.level)
            begin
                result.next.level = cur_x;
            end
            else if ((cur_x - state.level) > ph_x)
            begin
                result.next.level   = cur_x;
                result.next.sample  = idx;
                result.next.is_open = 1'b1;
            end
        end
        else
        begin
            result.next.level     = lv1;
            result.next.sample    = sp1;
            result.next.confirmed = conf1;
            if (conf1 && (idx >= sp1) && ((idx - sp1) > half_win))
            begin
                result.emit           = 1'b1;
                result.next.is_open   = 1'b0;
                result.next.level     = cur_x;
                result.next.confirmed = 1'b0;
            end
        end
    end

endmodule

@@ rtl/pkdet_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak detector merge stage
// Applies the short-channel mask to the long lane and orders the results.
// ----------------------------------------------------------------------------
module pkdet_merge (
    input  pkdet_pkg::lane_out_t             short_res,
    input  pkdet_pkg::lane_out_t             long_res,
    input  pkdet_pkg::lane_state_t           short_state,
    input  pkdet_pkg::lane_state_t           long_state,
    input  logic [pkdet_pkg::TSTAT_BITS-1:0] long_cur,
    input  logic [pkdet_pkg::INDEX_BITS-1:0] idx,
    input  logic [pkdet_pkg::MASK_BITS-1:0]  mask_until,
    input  logic [pkdet_pkg::TSTAT_BITS-1:0] short_threshold,
    input  logic [pkdet_pkg::WIN_BITS-1:0]   short_window,
    output pkdet_pkg::lane_state_t           short_next,
    output pkdet_pkg::lane_state_t           long_next,
    output logic [pkdet_pkg::MASK_BITS-1:0]  mask_next,
    output pkdet_pkg::result_t               res0,
    output pkdet_pkg::result_t               res1,
    output logic [1:0]                       res_count
);

    logic short_run;
    logic kill_long;
    logic long_skip;
    logic short_emit;
    logic long_emit;
    pkdet_pkg::result_t short_item;
    pkdet_pkg::result_t long_item;

    assign short_run = (idx != '0);

    // A strong open short peak resets the long channel and masks it.
    assign kill_long = short_run && short_res.was_open
                     && (short_res.upd_level > {1'b0, short_threshold});

    assign mask_next = kill_long
        ? ({1'b0, short_res.upd_sample} + pkdet_pkg::MASK_BITS'(short_window))
        : mask_until;

    assign long_skip = (mask_next >= {1'b0, idx});

    assign short_next = short_run ? short_res.next : short_state;
    assign short_emit = short_run && short_res.emit;
    assign long_emit  = !kill_long && !long_skip && long_res.emit;

    always_comb
    begin
        long_next = long_state;
        if (kill_long)
        begin
            if (long_skip)
            begin
                long_next = pkdet_pkg::LANE_RESET;
            end
            else
            begin
                // A cleared channel simply takes the sample as its trough.
                long_next.level     = {1'b0, long_cur};
                long_next.is_open   = 1'b0;
                long_next.confirmed = 1'b0;
            end
        end
        else if (!long_skip)
        begin
            long_next = long_res.next;
        end
    end

    always_comb
    begin
        short_item.peak_position    = short_res.upd_sample[pkdet_pkg::POS_BITS-1:0];
        short_item.from_long_window = 1'b0;
        short_item.last_of_item     = !long_emit;
        long_item.peak_position     = long_res.upd_sample[pkdet_pkg::POS_BITS-1:0];
        long_item.from_long_window  = 1'b1;
        long_item.last_of_item      = 1'b1;
    end

    assign res0      = short_emit ? short_item : long_item;
    assign res1      = long_item;
    assign res_count = {1'b0, short_emit} + {1'b0, long_emit};

endmodule

@@ rtl/pkdet_outq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak detector result queue
// Small queue that takes up to two results a cycle and hands out one.
// ----------------------------------------------------------------------------
module pkdet_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         wr_count,
    input  pkdet_pkg::result_t wr_data0,
    input  pkdet_pkg::result_t wr_data1,
    input  logic               rd,
    output pkdet_pkg::result_t head,
    output logic               not_empty,
    output logic               no_room
);

    pkdet_pkg::result_t                 entry_reg [pkdet_pkg::OUTQ_DEPTH];
    logic [pkdet_pkg::OUTQ_AW-1:0]      wr_ptr_reg;
    logic [pkdet_pkg::OUTQ_AW-1:0]      wr_ptr_next;
    logic [pkdet_pkg::OUTQ_AW-1:0]      rd_ptr_reg;
    logic [pkdet_pkg::OUTQ_AW-1:0]      rd_ptr_next;
    logic [pkdet_pkg::OUTQ_CW-1:0]      count_reg;
    logic [pkdet_pkg::OUTQ_CW-1:0]      count_next;
    logic [pkdet_pkg::OUTQ_AW-1:0]      wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign wr_ptr_next  = wr_ptr_reg + pkdet_pkg::OUTQ_AW'(wr_count);
    assign rd_ptr_next  = rd_ptr_reg + pkdet_pkg::OUTQ_AW'(rd);
    assign count_next   = count_reg + pkdet_pkg::OUTQ_CW'(wr_count)
                        - pkdet_pkg::OUTQ_CW'(rd);

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    // Room for two results must be there before an item is taken.
    assign no_room   = (count_reg > pkdet_pkg::OUTQ_CW'(pkdet_pkg::OUTQ_DEPTH - 2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= wr_data0;
        end
        if (wr_count == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= wr_data1;
        end
    end

endmodule

@@ rtl/dual_window_peak_detector.sv @@
`timescale 1ns / 1ps
// Throughput: one item per cycle while items give at most one result each and
//   the output is not stalled; an item with two results hands them out in turn
//   through the single output port, and the four-entry result queue takes a new
//   item only while it has room for two; results are offered from its registers.
// Reset: rst_n clears the detector state, sample counter and queue at once and
//   loads the register defaults; a start-of-read item clears the detector too.
// ----------------------------------------------------------------------------
// Dual-window peak detector
// Short and long t-statistic channels run as two parallel lanes; a merge stage
// applies the short-peak mask to the long lane and queues the sample indexes
// of confirmed peaks, short channel first.
// ----------------------------------------------------------------------------
module dual_window_peak_detector (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [pkdet_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [pkdet_pkg::CFG_BITS-1:0]      cfg_data,
    // Input item channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                start_of_read,
    input  logic [pkdet_pkg::TSTAT_BITS-1:0]    short_tstat,
    input  logic [pkdet_pkg::TSTAT_BITS-1:0]    long_tstat,
    // Result item channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [pkdet_pkg::POS_BITS-1:0]      peak_position,
    output logic                                from_long_window,
    output logic                                last_of_item
);

    // Configuration registers.
    logic [pkdet_pkg::TSTAT_BITS-1:0] rise_min_reg;
    logic [pkdet_pkg::TSTAT_BITS-1:0] short_threshold_reg;
    logic [pkdet_pkg::TSTAT_BITS-1:0] long_threshold_reg;
    logic [pkdet_pkg::WIN_BITS-1:0]   short_window_reg;
    logic [pkdet_pkg::WIN_BITS-1:0]   long_window_reg;

    // Detector state.
    logic [pkdet_pkg::INDEX_BITS-1:0] sample_count_reg;
    logic [pkdet_pkg::INDEX_BITS-1:0] sample_count_next;
    pkdet_pkg::lane_state_t           short_state_reg;
    pkdet_pkg::lane_state_t           short_state_next;
    pkdet_pkg::lane_state_t           long_state_reg;
    pkdet_pkg::lane_state_t           long_state_next;
    logic [pkdet_pkg::MASK_BITS-1:0]  mask_until_reg;
    logic [pkdet_pkg::MASK_BITS-1:0]  mask_until_next;

    logic                             accept;
    logic                             pop;
    logic [pkdet_pkg::INDEX_BITS-1:0] idx;
    pkdet_pkg::lane_state_t           short_eff;
    pkdet_pkg::lane_state_t           long_eff;
    logic [pkdet_pkg::MASK_BITS-1:0]  mask_eff;
    pkdet_pkg::lane_out_t             short_res;
    pkdet_pkg::lane_out_t             long_res;
    pkdet_pkg::result_t               res0;
    pkdet_pkg::result_t               res1;
    pkdet_pkg::result_t               head;
    logic [1:0]                       res_count;
    logic                             q_not_empty;
    logic                             q_no_room;

    assign accept = in_valid && !in_stall;
    assign pop    = out_valid && !out_stall;

    // A start-of-read item sees a freshly cleared detector and is sample zero.
    assign idx       = start_of_read ? '0 : sample_count_reg;
    assign short_eff = start_of_read ? pkdet_pkg::LANE_RESET : short_state_reg;
    assign long_eff  = start_of_read ? pkdet_pkg::LANE_RESET : long_state_reg;
    assign mask_eff  = start_of_read ? '0 : mask_until_reg;

    // The counter stops at its top value; later samples share that index.
    assign sample_count_next = (idx == pkdet_pkg::IDX_MAX) ? idx : idx + 1'b1;

    // Both lanes evaluate the same sample side by side. The long lane always
    // runs on its own state; the merge stage decides whether the short
    // channel's mask overrides what it found.
    pkdet_lane u_short_lane (
        .cur         (short_tstat),
        .idx         (idx),
        .state       (short_eff),
        .rise_min    (rise_min_reg),
        .threshold   (short_threshold_reg),
        .window      (short_window_reg),
        .result      (short_res)
    );

    pkdet_lane u_long_lane (
        .cur         (long_tstat),
        .idx         (idx),
        .state       (long_eff),
        .rise_min    (rise_min_reg),
        .threshold   (long_threshold_reg),
        .window      (long_window_reg),
        .result      (long_res)
    );

    pkdet_merge u_merge (
        .short_res       (short_res),
        .long_res        (long_res),
        .short_state     (short_eff),
        .long_state      (long_eff),
        .long_cur        (long_tstat),
        .idx             (idx),
        .mask_until      (mask_eff),
        .short_threshold (short_threshold_reg),
        .short_window    (short_window_reg),
        .short_next      (short_state_next),
        .long_next       (long_state_next),
        .mask_next       (mask_until_next),
        .res0            (res0),
        .res1            (res1),
        .res_count       (res_count)
    );

    // The result queue separates the two channels, so an item is taken even
    // while an earlier result waits on a stalled output.
    pkdet_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_count  (accept ? res_count : 2'd0),
        .wr_data0  (res0),
        .wr_data1  (res1),
        .rd        (pop),
        .head      (head),
        .not_empty (q_not_empty),
        .no_room   (q_no_room)
    );

    assign in_stall         = q_no_room;
    assign out_valid        = q_not_empty;
    assign peak_position    = head.peak_position;
    assign from_long_window = head.from_long_window;
    assign last_of_item     = head.last_of_item;

    // Configuration writes; indexes outside the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_min_reg        <= pkdet_pkg::TSTAT_BITS'(256);
            short_threshold_reg <= pkdet_pkg::TSTAT_BITS'(2048);
            long_threshold_reg  <= pkdet_pkg::TSTAT_BITS'(1024);
            short_window_reg    <= pkdet_pkg::WIN_BITS'(6);
            long_window_reg     <= pkdet_pkg::WIN_BITS'(12);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pkdet_pkg::REG_RISE_MIN:
                begin
                    rise_min_reg <= cfg_data[pkdet_pkg::TSTAT_BITS-1:0];
                end
                pkdet_pkg::REG_SHORT_THRESHOLD:
                begin
                    short_threshold_reg <= cfg_data[pkdet_pkg::TSTAT_BITS-1:0];
                end
                pkdet_pkg::REG_LONG_THRESHOLD:
                begin
                    long_threshold_reg <= cfg_data[pkdet_pkg::TSTAT_BITS-1:0];
                end
                pkdet_pkg::REG_SHORT_WINDOW:
                begin
                    short_window_reg <= cfg_data[pkdet_pkg::WIN_BITS-1:0];
                end
                pkdet_pkg::REG_LONG_WINDOW:
                begin
                    long_window_reg <= cfg_data[pkdet_pkg::WIN_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Detector state advances once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= '0;
            short_state_reg  <= pkdet_pkg::LANE_RESET;
            long_state_reg   <= pkdet_pkg::LANE_RESET;
            mask_until_reg   <= '0;
        end
        else if (accept)
        begin
            sample_count_reg <= sample_count_next;
            short_state_reg  <= short_state_next;
            long_state_reg   <= long_state_next;
            mask_until_reg   <= mask_until_next;
        end
    end

endmodule

@@ dv/peak_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak position checker
// Follows the register writes and the accepted items, predicts the peak
// positions that each item should produce, and compares every accepted result
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module peak_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pkdet_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [pkdet_pkg::CFG_BITS-1:0]      cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                start_of_read,
    input  logic [pkdet_pkg::TSTAT_BITS-1:0]    short_tstat,
    input  logic [pkdet_pkg::TSTAT_BITS-1:0]    long_tstat,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [pkdet_pkg::POS_BITS-1:0]      peak_position,
    input  logic                                from_long_window,
    input  logic                                last_of_item,
    output int                                  mismatches,
    output int                                  peaks_pending
);

    import pkdet_pkg::*;

    localparam int SHORT_LANE = 0;
    localparam int LONG_LANE  = 1;

    // Register copies.
    logic [TSTAT_BITS-1:0] height_cfg;
    logic [TSTAT_BITS-1:0] short_thr_cfg;
    logic [TSTAT_BITS-1:0] long_thr_cfg;
    logic [WIN_BITS-1:0]   short_win_cfg;
    logic [WIN_BITS-1:0]   long_win_cfg;

    // Detector state copy.
    logic [INDEX_BITS-1:0] sample_idx;
    logic [LEVEL_BITS-1:0] lane_level [2];
    logic [INDEX_BITS-1:0] lane_peak [2];
    bit                    lane_open [2];
    bit                    lane_conf [2];
    logic [MASK_BITS-1:0]  long_mask_end;

    result_t peaks_due [$];

    task automatic clear_detector();
        sample_idx = '0;
        for (int k = 0; k < 2; k++)
        begin
            lane_level[k] = TS_INF;
            lane_peak[k]  = '0;
            lane_open[k]  = 1'b0;
            lane_conf[k]  = 1'b0;
        end
        long_mask_end = '0;
    endtask

    // One lane of trough tracking, peak following, confirmation and hold-off.
    task automatic step_lane(input int k, input logic [INDEX_BITS-1:0] idx,
                             input logic [TSTAT_BITS-1:0] cur, output bit fired,
                             output logic [INDEX_BITS-1:0] pos);
        logic [LEVEL_BITS-1:0] thr;
        logic [LEVEL_BITS-1:0] cur_w;
        logic [LEVEL_BITS-1:0] height_w;
        logic [WIN_BITS-1:0]   win;
        thr      = (k == SHORT_LANE) ? {1'b0, short_thr_cfg} : {1'b0, long_thr_cfg};
        win      = (k == SHORT_LANE) ? short_win_cfg : long_win_cfg;
        cur_w    = {1'b0, cur};
        height_w = {1'b0, height_cfg};
        fired    = 1'b0;
        pos      = '0;
        if (!lane_open[k])
        begin
            if (cur_w < lane_level[k])
                lane_level[k] = cur_w;
            else if (cur_w - lane_level[k] > height_w)
            begin
                lane_level[k] = cur_w;
                lane_peak[k]  = idx;
                lane_open[k]  = 1'b1;
            end
        end
        else
        begin
            if (cur_w > lane_level[k])
            begin
                lane_level[k] = cur_w;
                lane_peak[k]  = idx;
            end
            // A strong short peak resets the long lane and masks it for a window.
            if (k == SHORT_LANE && lane_level[SHORT_LANE] > {1'b0, short_thr_cfg})
            begin
                long_mask_end = {1'b0, lane_peak[SHORT_LANE]}
                              + {{(MASK_BITS-WIN_BITS){1'b0}}, short_win_cfg};
                lane_open[LONG_LANE]  = 1'b0;
                lane_level[LONG_LANE] = TS_INF;
                lane_conf[LONG_LANE]  = 1'b0;
            end
            if (lane_level[k] > cur_w && lane_level[k] - cur_w > height_w
                && lane_level[k] > thr)
                lane_conf[k] = 1'b1;
            if (lane_conf[k] && idx >= lane_peak[k]
                && idx - lane_peak[k] > {{(INDEX_BITS-WIN_BITS+1){1'b0}}, win[WIN_BITS-1:1]})
            begin
                pos           = lane_peak[k];
                lane_open[k]  = 1'b0;
                lane_level[k] = cur_w;
                lane_conf[k]  = 1'b0;
                fired         = 1'b1;
            end
        end
    endtask

    task automatic predict_peaks(input bit first, input logic [TSTAT_BITS-1:0] s,
                                 input logic [TSTAT_BITS-1:0] l);
        logic [INDEX_BITS-1:0] idx;
        logic [INDEX_BITS-1:0] pos;
        bit                    fired;
        bit                    skip;
        result_t               found [2];
        int                    n;
        if (first)
            clear_detector();
        idx = sample_idx;
        n   = 0;
        for (int k = 0; k < 2; k++)
        begin
            if (k == SHORT_LANE)
                skip = (idx == '0);
            else
                skip = (long_mask_end >= {1'b0, idx});
            if (!skip)
            begin
                step_lane(k, idx, (k == SHORT_LANE) ? s : l, fired, pos);
                if (fired)
                begin
                    found[n].peak_position    = pos[POS_BITS-1:0];
                    found[n].from_long_window = (k == LONG_LANE);
                    found[n].last_of_item     = 1'b0;
                    n++;
                end
            end
        end
        for (int i = 0; i < n; i++)
        begin
            found[i].last_of_item = (i == n - 1);
            peaks_due = {peaks_due, found[i]};
        end
        if (sample_idx != IDX_MAX)
            sample_idx = sample_idx + 1'b1;
    endtask

    task automatic check_result();
        result_t want;
        if (peaks_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result: pos %0d long %0b last %0b",
                         $realtime, peak_position, from_long_window, last_of_item);
        end
        else
        begin
            want = peaks_due.pop_front();
            if (peak_position !== want.peak_position
                || from_long_window !== want.from_long_window
                || last_of_item !== want.last_of_item)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $write("%0t: result mismatch: expected pos %0d long %0b last %0b,",
                           $realtime, want.peak_position, want.from_long_window,
                           want.last_of_item);
                    $display(" got pos %0d long %0b last %0b",
                             peak_position, from_long_window, last_of_item);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_cfg    = 24'd256;
            short_thr_cfg = 24'd2048;
            long_thr_cfg  = 24'd1024;
            short_win_cfg = 12'd6;
            long_win_cfg  = 12'd12;
            clear_detector();
            peaks_due.delete();
            mismatches = 0;
        end
        else
        begin
            // Results of an item come out of the registered result queue, never in the cycle that accepts it.
            if (out_valid && !out_stall)
                check_result();
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RISE_MIN:        height_cfg    = cfg_data[TSTAT_BITS-1:0];
                    REG_SHORT_THRESHOLD: short_thr_cfg = cfg_data[TSTAT_BITS-1:0];
                    REG_LONG_THRESHOLD:  long_thr_cfg  = cfg_data[TSTAT_BITS-1:0];
                    REG_SHORT_WINDOW:    short_win_cfg = cfg_data[WIN_BITS-1:0];
                    REG_LONG_WINDOW:     long_win_cfg  = cfg_data[WIN_BITS-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_peaks(start_of_read, short_tstat, long_tstat);
        end
        peaks_pending = peaks_due.size();
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-window peak detector testbench
// Drives directed and random reads of t-statistic samples through the detector
// under several register settings, with random gaps on both channels, and
// lets a separate checker predict and compare the peak positions.
// ----------------------------------------------------------------------------
module tb;

    import pkdet_pkg::*;

    // The watchdog fires when its count of quiet cycles reaches this limit.
    // The longest quiet stretch of a correct run is a sender gap plus a receiver
    // stall plus a short settle.
    localparam int QUIET_LIMIT = 2000;

    logic                    clk;
    logic                    rst_n         = 1'b0;
    logic                    cfg_we        = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index     = '0;
    logic [CFG_BITS-1:0]     cfg_data      = '0;
    logic                    in_valid      = 1'b0;
    logic                    in_stall;
    logic                    start_of_read = 1'b0;
    logic [TSTAT_BITS-1:0]   short_tstat   = '0;
    logic [TSTAT_BITS-1:0]   long_tstat    = '0;
    logic                    out_valid;
    logic                    out_stall     = 1'b0;
    logic [POS_BITS-1:0]     peak_position;
    logic                    from_long_window;
    logic                    last_of_item;

    int mismatches;
    int peaks_pending;

    // When calm is set neither side inserts gaps, so the block also sees
    // stretches of back-to-back traffic.
    bit calm = 1'b0;
    int items_sent = 0;
    int quiet_cycles = 0;

    // Synthetic signal: each channel ramps between random goal levels, which
    // gives troughs, rising peaks and falls of all sizes around the thresholds.
    longint wave_now [2]  = '{0, 0};
    longint wave_goal [2] = '{0, 0};
    int     wave_left [2] = '{0, 0};
    longint wave_span     = 24'h002000;

    dual_window_peak_detector i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .start_of_read    (start_of_read),
        .short_tstat      (short_tstat),
        .long_tstat       (long_tstat),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .peak_position    (peak_position),
        .from_long_window (from_long_window),
        .last_of_item     (last_of_item)
    );

    peak_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .start_of_read    (start_of_read),
        .short_tstat      (short_tstat),
        .long_tstat       (long_tstat),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .peak_position    (peak_position),
        .from_long_window (from_long_window),
        .last_of_item     (last_of_item),
        .mismatches       (mismatches),
        .peaks_pending    (peaks_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: counts cycles with no handshake and no register write.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result receiver: before each result it stalls for a random number of
    // cycles, then waits with the stall low until a result is taken.
    initial
    begin
        int hold;
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 11);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    // Next value of one channel's synthetic signal.
    function automatic logic [TSTAT_BITS-1:0] next_level(input int ch);
        int pick;
        if (wave_left[ch] == 0)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                wave_goal[ch] = 0;
            else if (pick == 1)
                wave_goal[ch] = 24'hFFFFFF;
            else
                wave_goal[ch] = $urandom_range(0, int'(wave_span));
            wave_left[ch] = $urandom_range(1, 8);
        end
        wave_now[ch] = wave_now[ch] + (wave_goal[ch] - wave_now[ch]) / wave_left[ch];
        wave_left[ch]--;
        return wave_now[ch][TSTAT_BITS-1:0];
    endfunction

    // Offers one item after a random gap and returns at the edge that takes it.
    // The valid stays high into the next item when no gap follows.
    task automatic send_item(input bit first, input logic [TSTAT_BITS-1:0] s,
                             input logic [TSTAT_BITS-1:0] l);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        start_of_read <= first;
        short_tstat   <= s;
        long_tstat    <= l;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    // Stops the input, waits until every predicted result has been taken, then
    // lets the number of cycles given by extra pass, since items without a
    // result may still be in flight. The pending count is read on the falling
    // edge, away from the edge where the checker updates it.
    task automatic settle(input int extra);
        in_valid <= 1'b0;
        do @(negedge clk); while (peaks_pending != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Writes all five registers; window words may carry upper bits, which
    // the block drops.
    task automatic apply_settings(input logic [CFG_BITS-1:0] height,
                                  input logic [CFG_BITS-1:0] short_thr,
                                  input logic [CFG_BITS-1:0] long_thr,
                                  input logic [CFG_BITS-1:0] short_win_word,
                                  input logic [CFG_BITS-1:0] long_win_word);
        longint top_thr;
        write_reg(REG_RISE_MIN, height);
        write_reg(REG_SHORT_THRESHOLD, short_thr);
        write_reg(REG_LONG_THRESHOLD, long_thr);
        write_reg(REG_SHORT_WINDOW, short_win_word);
        write_reg(REG_LONG_WINDOW, long_win_word);
        cfg_we <= 1'b0;
        // Keep most signal levels within reach of the thresholds.
        top_thr   = (short_thr > long_thr) ? short_thr : long_thr;
        wave_span = 2 * top_thr + 4 * longint'(height) + 64;
        if (wave_span > 24'hFFFFFF)
            wave_span = 24'hFFFFFF;
    endtask

    // One read: a start item and then samples of the synthetic signal. A few
    // reads are noisy, and now and then a read is cut short by a new start.
    task automatic run_read(input int len);
        bit noisy;
        bit first;
        noisy = ($urandom_range(0, 4) == 0);
        calm  = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
        begin
            first = (i == 0) || ($urandom_range(0, 59) == 0);
            if (noisy && $urandom_range(0, 1) == 1)
                send_item(first, TSTAT_BITS'($urandom), TSTAT_BITS'($urandom));
            else
                send_item(first, next_level(0), next_level(1));
        end
    endtask

    // The last read of a phase is trimmed so the phase sends its budget exactly.
    task automatic run_phase(input logic [CFG_BITS-1:0] height,
                             input logic [CFG_BITS-1:0] short_thr,
                             input logic [CFG_BITS-1:0] long_thr,
                             input logic [CFG_BITS-1:0] short_win_word,
                             input logic [CFG_BITS-1:0] long_win_word,
                             input int budget);
        int goal;
        int len;
        settle(4);
        apply_settings(height, short_thr, long_thr, short_win_word, long_win_word);
        goal = items_sent + budget;
        while (items_sent < goal)
        begin
            len = $urandom_range(8, 48);
            if (len > goal - items_sent)
                len = goal - items_sent;
            run_read(len);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed read under the reset settings. Sample zero carries the
        // largest values and must be skipped by both channels.
        send_item(1'b1, 24'hFFFFFF, 24'hFFFFFF);
        send_item(1'b0, 24'h000000, 24'h000000);
        // A long-channel peak that rises, falls, and is reported after the
        // hold-off of half the long window.
        send_item(1'b0, 24'h000000, 24'h000600);
        send_item(1'b0, 24'h000000, 24'h000900);
        repeat (7) send_item(1'b0, 24'h000000, 24'h000100);
        // A strong short peak opens, masks the long channel and is reported.
        send_item(1'b0, 24'h001000, 24'h001000);
        send_item(1'b0, 24'h001200, 24'h001200);
        repeat (4) send_item(1'b0, 24'h000000, 24'h000000);
        send_item(1'b0, 24'hFFFFFF, 24'hFFFFFF);
        send_item(1'b0, 24'h000000, 24'h000000);
        // A new read cuts off the open peak.
        send_item(1'b1, 24'hFFFFFF, 24'h000000);
        send_item(1'b0, 24'h000000, 24'hFFFFFF);

        // Lowest settings: any rise opens a peak, windows of one.
        run_phase(24'h000000, 24'h000000, 24'h000000, 24'hFFF001, 24'h000001, 100);
        // Highest settings: no rise is ever large enough.
        run_phase(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000FFF, 24'hABCFFF, 40);
        // A zero short window: no hold-off and a mask that ends at the peak.
        run_phase(24'h000080, 24'h000400, 24'h000200, 24'hABC000, 24'h000003, 100);
        // A zero long window.
        run_phase(24'h000200, 24'h001000, 24'h000800, 24'h000008, 24'h555000, 100);
        // Random settings with mostly short windows.
        for (int p = 0; p < 5; p++)
            run_phase(CFG_BITS'($urandom_range(0, 1024)),
                      CFG_BITS'($urandom_range(0, 8192)),
                      CFG_BITS'($urandom_range(0, 8192)),
                      {12'($urandom), 12'($urandom_range(1, 24))},
                      {12'($urandom), 12'($urandom_range(1, 24))},
                      100);

        // Drain, then give any stray result time to show up.
        settle(20);
        if (mismatches == 0 && peaks_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
